>>> design/dcwb_pkg.sv
// Shared types and constants for the two-channel window and blend block.
// Used by the window stage module and the top level; depends on nothing.
package dcwb_pkg;

   localparam int SampleWidth = 16;
   localparam int GainWidth   = 26;
   localparam int LevelWidth  = 10;
   localparam int MixWidth    = 7;
   localparam int TintWidth   = 48;
   localparam int CsrWidth    = 48;
   localparam int IndexWidth  = 3;
   localparam int NumStages   = 7;

   localparam logic [LevelWidth-1:0] LEVEL_MAX  = 10'd1023;
   localparam logic [MixWidth-1:0]   MIX_FULL   = 7'd100;
   localparam logic [1:0]            PACK_TOP   = 2'b11;

   // Division by 25600 is a shift by 8 and a division by 100, the latter done
   // as a multiply by ceil(2^24 / 100); exact for dividends up to 199727.
   localparam int               DIV_SHIFT   = 8;
   localparam logic [17:0]      RECIP_100   = 18'd167773;
   localparam int               RECIP_SHIFT = 24;

   localparam logic [IndexWidth-1:0] REG_LOW_ONE  = 3'd0;
   localparam logic [IndexWidth-1:0] REG_HIGH_ONE = 3'd1;
   localparam logic [IndexWidth-1:0] REG_LOW_TWO  = 3'd2;
   localparam logic [IndexWidth-1:0] REG_HIGH_TWO = 3'd3;
   localparam logic [IndexWidth-1:0] REG_GAIN_ONE = 3'd4;
   localparam logic [IndexWidth-1:0] REG_GAIN_TWO = 3'd5;
   localparam logic [IndexWidth-1:0] REG_MIX      = 3'd6;
   localparam logic [IndexWidth-1:0] REG_TINT     = 3'd7;

   localparam logic [SampleWidth-1:0] LOW_RESET  = 16'd0;
   localparam logic [SampleWidth-1:0] HIGH_RESET = 16'd16383;
   localparam logic [GainWidth-1:0]   GAIN_RESET = 26'd4096;
   localparam logic [MixWidth-1:0]    MIX_RESET  = 7'd50;
   localparam logic [TintWidth-1:0]   TINT_RESET = 48'hFFFF00FF0000;

   // Load enables for the three window stages of one channel.
   typedef struct packed {
      logic diff;
      logic prod;
      logic level;
   } win_en_type;

endpackage

>>> design/dcwb_window.sv
// Three-stage window and gain for one channel: compare, multiply, saturate.
// Depends on dcwb_pkg for widths and the stage enable struct.
module dcwb_window (
   input  logic                             clock,
   input  dcwb_pkg::win_en_type             stage_en,
   input  logic [dcwb_pkg::SampleWidth-1:0] sample,
   input  logic [dcwb_pkg::SampleWidth-1:0] low_limit,
   input  logic [dcwb_pkg::SampleWidth-1:0] high_limit,
   input  logic [dcwb_pkg::GainWidth-1:0]   gain,
   output logic [dcwb_pkg::LevelWidth-1:0]  level
);
   import dcwb_pkg::*;

   localparam int ProdWidth = SampleWidth + GainWidth;

   logic [SampleWidth-1:0] diff_ff, diff_in;
   logic                   above_ff, above_in;
   logic                   below_ff, below_in;
   logic [ProdWidth-1:0]   prod_ff, prod_in;
   logic                   above2_ff, below2_ff;
   logic [LevelWidth-1:0]  level_ff, level_in;

   always_comb begin
      above_in = sample > high_limit;
      below_in = sample < low_limit;
      diff_in  = sample - low_limit;
   end

   assign prod_in = {{GainWidth{1'b0}}, diff_ff} * {{SampleWidth{1'b0}}, gain};

   // The high test wins when the limits are crossed.
   always_comb begin
      if (above2_ff) begin
         level_in = LEVEL_MAX;
      end else if (below2_ff) begin
         level_in = '0;
      end else if (prod_ff[ProdWidth-1:16+LevelWidth] != '0) begin
         level_in = LEVEL_MAX;
      end else begin
         level_in = prod_ff[16+LevelWidth-1:16];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.diff) begin
         diff_ff  <= diff_in;
         above_ff <= above_in;
         below_ff <= below_in;
      end
      if (stage_en.prod) begin
         prod_ff   <= prod_in;
         above2_ff <= above_ff;
         below2_ff <= below_ff;
      end
      if (stage_en.level) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

>>> design/dual_channel_window_blend.sv
// Top level of the two-channel window and alpha blend pipeline.
// Depends on dcwb_pkg and instantiates dcwb_window once per channel.
//
//  channel  direction  tdata fields (low bit up)                      tlast
//  req_     in         sample_one 15:0, sample_two 31:16              in_frame_last
//  rsp_     out        red 9:0, green 19:10, blue 29:20, packed 61:30 out_frame_last
//  csr_     in         index 2:0, write data 47:0, written when csr_wen  -
//
// One item enters per cycle unless a stall on rsp_tready backs up to stage 0;
// the seven register stages are compare, gain multiply, saturate, weight multiply,
// tint multiply and sum, reciprocal multiply, and the output register.
// Reset is synchronous; it clears the stage valid bits and loads the configuration
// registers with their reset values, while stage data is left as it is.
// Each stage holds while the next one is full and stalled, so a stall on
// rsp_tready backs up stage by stage and empty stages keep taking items.
module dual_channel_window_blend (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_one 15:0, sample_two 31:16
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // red 9:0, green 19:10, blue 29:20, packed_word 61:30
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [dcwb_pkg::IndexWidth-1:0] csr_index,
   input  logic [dcwb_pkg::CsrWidth-1:0]   csr_wdata
);
   import dcwb_pkg::*;

   localparam int WeightProdWidth = LevelWidth + MixWidth;
   localparam int SumWidth        = WeightProdWidth + 8;
   localparam int DivInWidth      = SumWidth - DIV_SHIFT;
   localparam int QuotProdWidth   = DivInWidth + 18;

   // Configuration registers.
   logic [SampleWidth-1:0] low_one_ff, high_one_ff, low_two_ff, high_two_ff;
   logic [GainWidth-1:0]   gain_one_ff, gain_two_ff;
   logic [MixWidth-1:0]    mix_ff;
   logic [TintWidth-1:0]   tint_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_one_ff  <= LOW_RESET;
         high_one_ff <= HIGH_RESET;
         low_two_ff  <= LOW_RESET;
         high_two_ff <= HIGH_RESET;
         gain_one_ff <= GAIN_RESET;
         gain_two_ff <= GAIN_RESET;
         mix_ff      <= MIX_RESET;
         tint_ff     <= TINT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            REG_LOW_ONE:  low_one_ff  <= csr_wdata[SampleWidth-1:0];
            REG_HIGH_ONE: high_one_ff <= csr_wdata[SampleWidth-1:0];
            REG_LOW_TWO:  low_two_ff  <= csr_wdata[SampleWidth-1:0];
            REG_HIGH_TWO: high_two_ff <= csr_wdata[SampleWidth-1:0];
            REG_GAIN_ONE: gain_one_ff <= csr_wdata[GainWidth-1:0];
            REG_GAIN_TWO: gain_two_ff <= csr_wdata[GainWidth-1:0];
            REG_MIX:      mix_ff      <= csr_wdata[MixWidth-1:0];
            REG_TINT:     tint_ff     <= csr_wdata[TintWidth-1:0];
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage loads when it is empty or its item moves on.
   logic [NumStages-1:0] valid_ff, valid_in;
   logic [NumStages-1:0] load;
   logic [NumStages-1:0] last_ff;

   always_comb begin
      load[NumStages-1] = !valid_ff[NumStages-1] || rsp_tready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         last_ff[0] <= req_tlast;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (load[k]) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   assign req_tready = load[0];

   // Stages 0 to 2: windowing of both channels.
   win_en_type             win_en;
   logic [LevelWidth-1:0]  level_one, level_two;

   assign win_en = '{diff: load[0], prod: load[1], level: load[2]};

   dcwb_window u_window_one (
      .clock      (clock),
      .stage_en   (win_en),
      .sample     (req_tdata[15:0]),
      .low_limit  (low_one_ff),
      .high_limit (high_one_ff),
      .gain       (gain_one_ff),
      .level      (level_one)
   );

   dcwb_window u_window_two (
      .clock      (clock),
      .stage_en   (win_en),
      .sample     (req_tdata[31:16]),
      .low_limit  (low_two_ff),
      .high_limit (high_two_ff),
      .gain       (gain_two_ff),
      .level      (level_two)
   );

   // Stage 3: level times mix weight. A mix above one hundred counts as 100.
   logic [MixWidth-1:0]        mix_two, mix_one;
   logic [WeightProdWidth-1:0] wp_one_ff, wp_one_in, wp_two_ff, wp_two_in;

   always_comb begin
      mix_two   = (mix_ff > MIX_FULL) ? MIX_FULL : mix_ff;
      mix_one   = MIX_FULL - mix_two;
      wp_one_in = {{MixWidth{1'b0}}, level_one} * {{LevelWidth{1'b0}}, mix_one};
      wp_two_in = {{MixWidth{1'b0}}, level_two} * {{LevelWidth{1'b0}}, mix_two};
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         wp_one_ff <= wp_one_in;
         wp_two_ff <= wp_two_in;
      end
   end

   // Stage 4: tint products and their sum, one lane per color (red first).
   logic [SumWidth-1:0] sum_ff [3];
   logic [SumWidth-1:0] sum_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = {8'd0, wp_one_ff} * {{WeightProdWidth{1'b0}}, tint_ff[(2-c)*8 +: 8]}
                   + {8'd0, wp_two_ff} * {{WeightProdWidth{1'b0}}, tint_ff[24+(2-c)*8 +: 8]};
      end
   end

   // Stage 5: divide by 100 through the reciprocal, after the shift by 8.
   logic [QuotProdWidth-1:0] quot_ff [3];
   logic [QuotProdWidth-1:0] quot_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot_in[c] = {18'd0, sum_ff[c][SumWidth-1:DIV_SHIFT]}
                    * {{DivInWidth{1'b0}}, RECIP_100};
      end
   end

   // Stage 6: saturate and hold the result for the output channel.
   logic [LevelWidth-1:0] color_ff [3];
   logic [LevelWidth-1:0] color_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (quot_ff[c][QuotProdWidth-1:RECIP_SHIFT+LevelWidth] != '0) begin
            color_in[c] = LEVEL_MAX;
         end else begin
            color_in[c] = quot_ff[c][RECIP_SHIFT+LevelWidth-1:RECIP_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (load[4]) begin
            sum_ff[c] <= sum_in[c];
         end
         if (load[5]) begin
            quot_ff[c] <= quot_in[c];
         end
         if (load[6]) begin
            color_ff[c] <= color_in[c];
         end
      end
   end

   logic [31:0] packed_word;

   assign packed_word = {PACK_TOP, color_ff[0], color_ff[1], color_ff[2]};
   assign rsp_tdata   = {2'b00, packed_word, color_ff[2], color_ff[1], color_ff[0]};
   assign rsp_tvalid  = valid_ff[NumStages-1];
   assign rsp_tlast   = last_ff[NumStages-1];

endmodule

>>> design/dcwb_checker.sv
// Port-level checks for dual_channel_window_blend and the bind that attaches them.
// Sees only the top level's ports; no package needed.
module dcwb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A result held back by the consumer stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The packed word always carries its two marker bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[61:60] == 2'b11 && rsp_tdata[63:62] == 2'b00)
      else $error("packed word marker bits wrong");

   // The packed word repeats the three color levels in red, green, blue order.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[59:50] == rsp_tdata[9:0]
                  && rsp_tdata[49:40] == rsp_tdata[19:10]
                  && rsp_tdata[39:30] == rsp_tdata[29:20])
      else $error("packed word disagrees with color levels");

endmodule

bind dual_channel_window_blend dcwb_checker u_dcwb_checker (.*);
